>>> hdl/plane_sample_statistics_unit_assert.svh
// Assertion macros for the plane sample statistics unit.
// Expects aclk and aresetn in scope at the place of use.
`ifndef PLANE_SAMPLE_STATISTICS_UNIT_ASSERT_SVH
`define PLANE_SAMPLE_STATISTICS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("plane statistics check failed");

// Next-cycle implication, disabled during reset.
`define PSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("plane statistics check failed");

`endif

>>> hdl/pss_pkg.sv
// Shared constants and types of the plane sample statistics unit.
// No dependencies.
`default_nettype none

package pss_pkg;

    localparam int COUNT_BITS      = 24;
    localparam int CNT_W           = COUNT_BITS + 1;
    localparam int SUM_W           = 40;
    localparam int SAMPLE_W        = 16;
    localparam int DEPTH_W         = 5;
    localparam int TOTAL_W         = 25;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_FIELDS_W    = 5 * SAMPLE_W + TOTAL_W + 1;
    localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W       = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STEPS       = SUM_W;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);

    localparam logic [DEPTH_W-1:0] SAMPLE_DEPTH_RESET = 5'd10;

    // Snapshot of one finished plane, handed from the accumulator to the divider.
    typedef struct packed {
        logic [SAMPLE_W-1:0] min_val;
        logic [SAMPLE_W-1:0] max_val;
        logic [SUM_W-1:0]    sum;
        logic [CNT_W-1:0]    count;
        logic                overflow;
    } plane_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

>>> hdl/pss_queue.sv
// Short record queue between the accumulator and the divider back end.
// Depends on pss_pkg.
`default_nettype none

module pss_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire pss_pkg::plane_rec_t   push_rec,
    input  wire logic                  pop,
    output pss_pkg::plane_rec_t        pop_rec,
    output pss_pkg::queue_status_t     status
);
    import pss_pkg::*;

    plane_rec_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb begin
        status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
        status.empty = (count_reg == '0);
        pop_rec      = entries_reg[rd_ptr_reg];
        wr_ptr_next  = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next  = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pss_front.sv
// Accumulator front end: takes samples, keeps running min, max, sum and count.
// Depends on pss_pkg; feeds pss_queue.
`default_nettype none

module pss_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pss_pkg::IN_TDATA_W-1:0] s_tdata,  // [15:0] sample
    input  wire logic                          s_tlast,   // last_sample
    input  wire pss_pkg::queue_status_t        q_status,
    output logic                               push,
    output pss_pkg::plane_rec_t                push_rec
);
    import pss_pkg::*;

    logic [SAMPLE_W-1:0] min_reg, min_next, min_upd;
    logic [SAMPLE_W-1:0] max_reg, max_next, max_upd;
    logic [SUM_W-1:0]    sum_reg, sum_next, sum_upd, sum_add;
    logic [SUM_W:0]      sum_wide;
    logic [CNT_W-1:0]    count_reg, count_next, count_upd;
    logic                ovf_reg, ovf_next, ovf_upd;
    logic [SAMPLE_W-1:0] sample;
    logic                accept, sat;

    always_comb begin
        s_tready = !q_status.full;
        accept   = s_tvalid && s_tready;
        sample   = s_tdata[SAMPLE_W-1:0];

        min_upd  = (sample < min_reg) ? sample : min_reg;
        max_upd  = (sample > max_reg) ? sample : max_reg;
        // count never passes 2^COUNT_BITS, so its top bit marks saturation
        sat      = count_reg[COUNT_BITS];
        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(sample);
        sum_add  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        sum_upd  = sat ? sum_reg : sum_add;
        count_upd = sat ? count_reg : count_reg + CNT_W'(1);
        ovf_upd  = ovf_reg | sat;

        push              = accept && s_tlast;
        push_rec.min_val  = min_upd;
        push_rec.max_val  = max_upd;
        push_rec.sum      = sum_upd;
        push_rec.count    = count_upd;
        push_rec.overflow = ovf_upd;

        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            if (s_tlast) begin
                // plane done: start over
                min_next   = '1;
                max_next   = '0;
                sum_next   = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end else begin
                min_next   = min_upd;
                max_next   = max_upd;
                sum_next   = sum_upd;
                count_next = count_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= '1;
            max_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pss_back.sv
// Back end: serial mean divider, ceiling snap, output register, depth register.
// Depends on pss_pkg; drains pss_queue.
`default_nettype none

module pss_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pss_pkg::DEPTH_W-1:0]    cfg_data,   // sample_depth
    input  wire pss_pkg::queue_status_t         q_status,
    output logic                                pop,
    input  wire pss_pkg::plane_rec_t            pop_rec,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pss_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import pss_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam int LUMA_BASE   = 219 + 16;
    localparam int CHROMA_BASE = 224 + 16;
    localparam int SNAP_W      = 20;

    logic [1:0]             state_reg, state_next;
    logic [DIV_CNT_W-1:0]   step_reg, step_next;
    logic [SUM_W-1:0]       quot_reg, quot_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       divisor_reg, divisor_next;
    plane_rec_t             rec_reg, rec_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;

    logic [CNT_W:0]         shifted;
    logic [CNT_W-1:0]       rem_step;
    logic                   ge;
    logic [SAMPLE_W-1:0]    mean_val, ceil_val;

    function automatic logic [SAMPLE_W-1:0] snap_ceiling(
        input logic [SAMPLE_W-1:0] top,
        input logic [DEPTH_W-1:0]  depth
    );
        logic [3:0]        sh;
        logic [SNAP_W-1:0] luma, chroma, luma_q, chroma_q, t;
        if (depth < DEPTH_W'(8)) begin
            sh = 4'd0;
        end else if (depth > DEPTH_W'(16)) begin
            sh = 4'd8;
        end else begin
            sh = 4'(depth - DEPTH_W'(8));
        end
        luma     = SNAP_W'(LUMA_BASE) << sh;
        chroma   = SNAP_W'(CHROMA_BASE) << sh;
        luma_q   = SNAP_W'(luma * SNAP_W'(3)) >> 2;
        chroma_q = SNAP_W'(chroma * SNAP_W'(3)) >> 2;
        t = SNAP_W'(top);
        if (t < luma && t > luma_q) begin
            t = luma;
        end
        if (t < chroma && t > chroma_q) begin
            t = chroma;
        end
        return t[SAMPLE_W-1:0];
    endfunction

    always_comb begin
        cfg_ready  = 1'b1;
        depth_next = (cfg_valid && cfg_ready) ? cfg_data : depth_reg;

        // one restoring division step per cycle
        shifted  = {rem_reg, quot_reg[SUM_W-1]};
        ge       = (shifted >= {1'b0, divisor_reg});
        rem_step = ge ? CNT_W'(shifted - {1'b0, divisor_reg}) : shifted[CNT_W-1:0];

        mean_val = (|quot_reg[SUM_W-1:SAMPLE_W]) ? '1 : quot_reg[SAMPLE_W-1:0];
        ceil_val = snap_ceiling(rec_reg.max_val, depth_reg);

        state_next     = state_reg;
        step_next      = step_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        rec_next       = rec_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    pop          = 1'b1;
                    rec_next     = pop_rec;
                    quot_next    = pop_rec.sum;
                    rem_next     = '0;
                    divisor_next = pop_rec.count;
                    step_next    = DIV_CNT_W'(DIV_STEPS);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                quot_next = {quot_reg[SUM_W-2:0], ge};
                rem_next  = rem_step;
                step_next = step_reg - DIV_CNT_W'(1);
                if (step_reg == DIV_CNT_W'(1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // load the output register once it is free
                if (!out_valid_reg || m_tready) begin
                    out_data_next  = {{OUT_PAD_W{1'b0}}, rec_reg.overflow,
                                      TOTAL_W'(rec_reg.count), ceil_val,
                                      rec_reg.min_val, mean_val,
                                      rec_reg.max_val, rec_reg.min_val};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
    end

    always_ff @(posedge aclk) begin
        step_reg     <= step_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        rec_reg      <= rec_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            depth_reg     <= SAMPLE_DEPTH_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/plane_sample_statistics_unit.sv
// Plane sample statistics unit: min, max, mean and range estimates per plane.
// Throughput: one sample per cycle while the queue is not full; the 40-step serial divider
//   works on one plane at a time, and a 2-entry queue absorbs planes that arrive faster.
// Each finished plane passes through the queue, the divider and the output register to m_tvalid.
// Reset (aresetn low, synchronous): running stats cleared, queue emptied, sample depth = 10.
`default_nettype none

`include "plane_sample_statistics_unit_assert.svh"

module plane_sample_statistics_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // sample stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pss_pkg::IN_TDATA_W-1:0]    s_tdata,  // [15:0] sample
    input  wire logic                              s_tlast,  // last_sample
    // per-plane result
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [15:0] min_value, [31:16] max_value, [47:32] mean_value,
    // [63:48] floor_estimate, [79:64] ceiling_estimate,
    // [104:80] sample_total, [105] count_overflow, [111:106] zero
    output logic [pss_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // sample depth register write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pss_pkg::DEPTH_W-1:0]       cfg_data  // sample_depth
);
    import pss_pkg::*;

    logic           push, pop;
    plane_rec_t     push_rec, pop_rec;
    queue_status_t  q_status;

    // Front end: accumulate each plane and hand a snapshot over on the last sample.
    // It stalls only when the queue is full.
    pss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_rec (push_rec)
    );

    // Decouple the sample rate from the slow per-plane divide.
    pss_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .status   (q_status)
    );

    // Back end: divide sum by count one bit per cycle, snap the ceiling,
    // and hold the result in the output register until taken.
    pss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .pop       (pop),
        .pop_rec   (pop_rec),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Never write into a full queue or read from an empty one.
    `PSS_ASSERT_IMP(a_no_push_full, push, !q_status.full)
    `PSS_ASSERT_IMP(a_no_pop_empty, pop, !q_status.empty)
    // An empty queue stays empty without a push.
    `PSS_ASSERT_NEXT(a_empty_holds, q_status.empty && !push, q_status.empty)
    // The mean of a plane lies between its minimum and maximum.
    `PSS_ASSERT_IMP(a_mean_in_range, m_tvalid, (m_tdata[15:0] <= m_tdata[47:32]) && (m_tdata[47:32] <= m_tdata[31:16]))

endmodule

`default_nettype wire

>>> bench/plane_sample_statistics_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for plane_sample_statistics_unit: per-plane min, max, mean,
// floor and ceiling estimates, sample count and overflow flag, checked against a
// predictor kept in the bench. Depends on pss_pkg and the unit's RTL.

module plane_sample_statistics_unit_test;
    import pss_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int DRAIN_CYCLES = 60;   // settling margin for the divider after the last result
    localparam int MAX_WAIT     = 18;
    localparam int LONG_PLANE   = 64;   // one gap-free plane of bright samples

    localparam logic [SUM_W-1:0] SUM_CEILING = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] COUNT_CAP   = CNT_W'(64'd1 << COUNT_BITS);

    // One finished plane, in the field order of m_tdata.
    typedef struct packed {
        logic [SAMPLE_W-1:0] min_value;
        logic [SAMPLE_W-1:0] max_value;
        logic [SAMPLE_W-1:0] mean_value;
        logic [SAMPLE_W-1:0] floor_estimate;
        logic [SAMPLE_W-1:0] ceiling_estimate;
        logic [TOTAL_W-1:0]  sample_total;
        logic                count_overflow;
    } plane_stats_t;

    // ---------------------------------------------------------------------
    // Clock, reset and DUT ports; every input is known from time zero.
    // ---------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;    // [15:0] sample
    logic                   s_tlast   = 1'b0;  // last_sample
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [15:0] min, [31:16] max, [47:32] mean, [63:48] floor, [79:64] ceiling,
    // [104:80] sample_total, [105] count_overflow, rest zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [DEPTH_W-1:0]     cfg_data  = '0;    // sample_depth

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    plane_sample_statistics_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Predictor state: the sample depth register and the running plane stats.
    // ---------------------------------------------------------------------
    logic [DEPTH_W-1:0]  depth_reg = SAMPLE_DEPTH_RESET;
    logic [SAMPLE_W-1:0] plane_min;
    logic [SAMPLE_W-1:0] plane_max;
    logic [SUM_W-1:0]    plane_sum;
    logic [CNT_W-1:0]    plane_count;
    logic                plane_ovf;

    plane_stats_t pending_plane_stats[$];
    int unsigned  mismatch_count = 0;
    int unsigned  result_index   = 0;
    int unsigned  cycle_count    = 0;
    bit           tx_steady      = 1'b0;  // sender never idles while set
    bit           rx_steady      = 1'b0;  // receiver never stalls while set

    function automatic void clear_plane();
        plane_min   = '1;
        plane_max   = '0;
        plane_sum   = '0;
        plane_count = '0;
        plane_ovf   = 1'b0;
    endfunction

    // Depths outside 8..16 act as the nearest end of that range.
    function automatic int unsigned range_scale();
        int unsigned eff;
        eff = depth_reg;
        if (eff < 8)
            eff = 8;
        if (eff > 16)
            eff = 16;
        return 1 << (eff - 8);
    endfunction

    // Snap the plane maximum up to the video-range luma top, then chroma top,
    // when it lies in the upper quarter just below either.
    function automatic logic [SAMPLE_W-1:0] video_range_ceiling(logic [SAMPLE_W-1:0] top);
        int unsigned d, luma_top, chroma_top, t;
        d          = range_scale();
        luma_top   = 235 * d;
        chroma_top = 240 * d;
        t          = top;
        if (t < luma_top && t > (luma_top * 3) / 4)
            t = luma_top;
        if (t < chroma_top && t > (chroma_top * 3) / 4)
            t = chroma_top;
        return SAMPLE_W'(t);
    endfunction

    // Fold one accepted sample into the plane; on the last one, queue the result.
    function automatic void absorb_sample(logic [SAMPLE_W-1:0] smp, bit last);
        logic [SUM_W:0]   wide_sum;
        logic [SUM_W-1:0] quotient;
        plane_stats_t     r;
        if (smp < plane_min)
            plane_min = smp;
        if (smp > plane_max)
            plane_max = smp;
        if (plane_count >= COUNT_CAP) begin
            plane_ovf = 1'b1;
        end else begin
            plane_count = plane_count + CNT_W'(1);
            wide_sum    = {1'b0, plane_sum} + (SUM_W + 1)'(smp);
            plane_sum   = (wide_sum > SUM_CEILING) ? SUM_CEILING : wide_sum[SUM_W-1:0];
        end
        if (last) begin
            quotient           = plane_sum / SUM_W'(plane_count);
            r.min_value        = plane_min;
            r.max_value        = plane_max;
            r.mean_value       = (quotient > 'hFFFF) ? '1 : quotient[SAMPLE_W-1:0];
            r.floor_estimate   = plane_min;
            r.ceiling_estimate = video_range_ceiling(plane_max);
            r.sample_total     = plane_count[TOTAL_W-1:0];
            r.count_overflow   = plane_ovf;
            pending_plane_stats.push_back(r);
            clear_plane();
        end
    endfunction

    // ---------------------------------------------------------------------
    // Run limit: a hung handshake ends the run here.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Result side: stall a random number of cycles after each item.
    // ---------------------------------------------------------------------
    int unsigned rx_hold = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                rx_hold = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
                if (rx_hold != 0)
                    m_tready <= 1'b0;
            end
        end else if (rx_hold <= 1) begin
            m_tready <= 1'b1;
            rx_hold = 0;
        end else begin
            rx_hold--;
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("plane %0d %s: got %0d, expected %0d", result_index, what, got, want);
        mismatch_count++;
    endtask

    // Compare each accepted result with the oldest pending plane.
    always @(posedge aclk) begin : result_check
        plane_stats_t got;
        plane_stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.min_value        = m_tdata[15:0];
            got.max_value        = m_tdata[31:16];
            got.mean_value       = m_tdata[47:32];
            got.floor_estimate   = m_tdata[63:48];
            got.ceiling_estimate = m_tdata[79:64];
            got.sample_total     = m_tdata[104:80];
            got.count_overflow   = m_tdata[105];
            if (pending_plane_stats.size() == 0) begin
                report_mismatch("arrived with none pending", got.min_value, 0);
            end else begin
                want = pending_plane_stats.pop_front();
                if (got.min_value != want.min_value)
                    report_mismatch("min_value", got.min_value, want.min_value);
                if (got.max_value != want.max_value)
                    report_mismatch("max_value", got.max_value, want.max_value);
                if (got.mean_value != want.mean_value)
                    report_mismatch("mean_value", got.mean_value, want.mean_value);
                if (got.floor_estimate != want.floor_estimate)
                    report_mismatch("floor_estimate", got.floor_estimate,
                                    want.floor_estimate);
                if (got.ceiling_estimate != want.ceiling_estimate)
                    report_mismatch("ceiling_estimate", got.ceiling_estimate,
                                    want.ceiling_estimate);
                if (got.sample_total != want.sample_total)
                    report_mismatch("sample_total", got.sample_total, want.sample_total);
                if (got.count_overflow != want.count_overflow)
                    report_mismatch("count_overflow", got.count_overflow,
                                    want.count_overflow);
            end
            result_index++;
        end
    end

    // ---------------------------------------------------------------------
    // Sample side: idle a random gap, present the item, hold it until taken.
    // Always entered and left at a rising edge.
    // ---------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit last);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        absorb_sample(smp, last);
    endtask

    // Drop valid, wait for every pending plane, then let the divider settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_plane_stats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sample_depth(input logic [DEPTH_W-1:0] depth);
        cfg_valid <= 1'b1;
        cfg_data  <= depth;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        depth_reg = depth;
    endtask

    // Mix of full-range, dark and near-threshold values for the current depth.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned d, base;
        d = range_scale();
        case ($urandom_range(0, 3))
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($urandom_range(0, 255));
            default: begin
                case ($urandom_range(0, 3))
                    0: base = 235 * d;
                    1: base = (235 * d * 3) / 4;
                    2: base = 240 * d;
                    default: base = (240 * d * 3) / 4;
                endcase
                return SAMPLE_W'(base + $urandom_range(0, 4) - 2);
            end
        endcase
    endfunction

    task automatic send_plane(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_sample(pick_sample(), i == len - 1);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset depth: sample extremes and both snap thresholds, edges on each side.
    task automatic test_reset_depth();
        int unsigned d, luma_top, chroma_top;
        d          = range_scale();
        luma_top   = 235 * d;
        chroma_top = 240 * d;
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(SAMPLE_W'((luma_top * 3) / 4), 1'b1);
        send_sample(SAMPLE_W'((luma_top * 3) / 4 + 1), 1'b1);
        send_sample(SAMPLE_W'(luma_top - 1), 1'b1);
        send_sample(SAMPLE_W'(luma_top), 1'b1);
        send_sample(SAMPLE_W'((chroma_top * 3) / 4), 1'b1);
        send_sample(SAMPLE_W'((chroma_top * 3) / 4 + 1), 1'b1);
        send_sample(SAMPLE_W'(chroma_top - 1), 1'b1);
        send_sample(SAMPLE_W'(chroma_top), 1'b1);
        send_sample(SAMPLE_W'(chroma_top + 1), 1'b1);
        wait_drained();
    endtask

    // One gap-free plane of bright samples against a stalling receiver.
    task automatic test_long_plane();
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        for (int unsigned i = 0; i < LONG_PLANE; i++)
            send_sample(SAMPLE_W'($urandom_range(65000, 65535)), i == LONG_PLANE - 1);
        tx_steady = 1'b0;
        wait_drained();
    endtask

    // Random planes over several depths, including out-of-range ones.
    task automatic test_random_planes();
        logic [DEPTH_W-1:0] depth_plan[7];
        int unsigned        sent, len;
        depth_plan = '{5'd8, 5'd16, 5'd0, 5'd31, 5'd13, 5'd0, 5'd0};
        depth_plan[5] = DEPTH_W'($urandom);
        depth_plan[6] = DEPTH_W'($urandom_range(8, 16));
        foreach (depth_plan[p]) begin
            write_sample_depth(depth_plan[p]);
            // one phase runs flat out on both sides, the rest mostly idle at random
            tx_steady = (p == 2) || ($urandom_range(0, 3) == 0);
            rx_steady = (p == 2) || ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < 60) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 5);
                send_plane(len);
                sent += len;
            end
            wait_drained();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        clear_plane();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_depth();
        test_random_planes();
        test_long_plane();
        wait_drained();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/pss_pkg.sv
hdl/pss_queue.sv
hdl/pss_front.sv
hdl/pss_back.sv
hdl/plane_sample_statistics_unit.sv
bench/plane_sample_statistics_unit_test.sv
